[hdl/v29e_pkg.sv]
// ----------------------------------------------------------------------------
// v29e_pkg
// Types, constants and point tables for the V.29 symbol encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package v29e_pkg;

	// rate codes; the spare code behaves as 9600
	localparam logic [1:0] RATE_9600 = 2'd0;
	localparam logic [1:0] RATE_7200 = 2'd1;
	localparam logic [1:0] RATE_4800 = 2'd2;

	// training segment boundaries in bauds
	localparam logic [9:0] SEG2_START = 10'd48;
	localparam logic [9:0] SEG3_START = 10'd176;
	localparam logic [9:0] SEG4_START = 10'd560;
	localparam logic [9:0] TRAIN_END  = 10'd608;

	localparam logic [6:0] TRAIN_SCR_INIT = 7'h2A;

	typedef logic signed [3:0] coord_t;

	typedef struct packed {
		logic [22:0] data_scr;
		logic [6:0]  train_scr;
		logic [2:0]  phase;
		logic [9:0]  train_count;
		logic        in_train;
	} v29e_state_t;

	localparam v29e_state_t STATE_INIT = '{
		data_scr:    23'd0,
		train_scr:   TRAIN_SCR_INIT,
		phase:       3'd0,
		train_count: 10'd0,
		in_train:    1'b1
	};

	typedef struct packed {
		coord_t point_i;
		coord_t point_q;
		logic   training;
		logic   data_taken;
	} v29e_result_t;

	// points by phase, plus 8 for the high amplitude
	localparam coord_t PT_I [16] = '{
		4'sd3, 4'sd1, 4'sd0, -4'sd1, -4'sd3, -4'sd1, 4'sd0, 4'sd1,
		4'sd5, 4'sd3, 4'sd0, -4'sd3, -4'sd5, -4'sd3, 4'sd0, 4'sd3
	};
	localparam coord_t PT_Q [16] = '{
		4'sd0, 4'sd1, 4'sd3, 4'sd1, 4'sd0, -4'sd1, -4'sd3, -4'sd1,
		4'sd0, 4'sd3, 4'sd5, 4'sd3, 4'sd0, -4'sd3, -4'sd5, -4'sd3
	};

	// training points by rate offset plus alternate/scrambler bit
	localparam coord_t AB_I [6] = '{-4'sd3, 4'sd3, -4'sd3, 4'sd1, -4'sd3, 4'sd0};
	localparam coord_t AB_Q [6] = '{4'sd0, -4'sd3, 4'sd0, -4'sd1, 4'sd0, -4'sd3};
	localparam coord_t CD_I [6] = '{4'sd3, -4'sd3, 4'sd3, -4'sd1, 4'sd3, 4'sd0};
	localparam coord_t CD_Q [6] = '{4'sd0, 4'sd3, 4'sd0, 4'sd1, 4'sd0, 4'sd3};

	// gray phase steps
	localparam logic [2:0] STEP8 [8] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6, 3'd7, 3'd5, 3'd4};
	localparam logic [2:0] STEP4 [4] = '{3'd0, 3'd2, 3'd6, 3'd4};

endpackage

`default_nettype wire

[hdl/v29e_if.sv]
// ----------------------------------------------------------------------------
// v29e_in_if / v29e_out_if
// Valid/ready channels for user bits in and constellation points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface v29e_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] data_bits;
	logic       restart;

	modport source (output valid, output data_bits, output restart, input ready);
	modport sink   (input valid, input data_bits, input restart, output ready);
endinterface

interface v29e_out_if;
	logic              valid;
	logic              ready;
	logic signed [3:0] point_i;
	logic signed [3:0] point_q;
	logic              training;
	logic              data_taken;

	modport source (output valid, output point_i, output point_q, output training,
		output data_taken, input ready);
	modport sink   (input valid, input point_i, input point_q, input training,
		input data_taken, output ready);
endinterface

`default_nettype wire

[hdl/v29_symbol_encoder.sv]
// ----------------------------------------------------------------------------
// v29_symbol_encoder
// V.29 transmit symbol source: training sequence, data scrambler and
// differential Gray constellation mapper, one point per baud.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one baud of user bits plus a restart flag; dout carries one
//   constellation point with its training and data_taken flags. Every
//   transfer on din gives exactly one transfer on dout, in order.
//   The accepted item sits in an input register; the core logic between it
//   and the output register produces the point and the next encoder state.
//   The result becomes valid once it reaches the output register, and one baud
//   is taken every cycle while dout is ready.
//   The encoder state (scramblers, phase, training count) is updated when
//   the result moves into the output register.
//   When dout stalls, the output and input registers both fill and din.ready
//   drops; no item is lost or repeated. Reset clears the pipeline, sets rate_mode
//   to 9600 and starts training. The user writes rate_mode via cfg_we/cfg_wdata
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module v29_symbol_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	v29e_in_if.sink    din,
	v29e_out_if.source dout
);
	import v29e_pkg::*;

	logic [1:0]   rate_mode_q;
	v29e_state_t  st_q;
	v29e_state_t  st_next;
	v29e_result_t res;
	v29e_result_t res_q;
	logic         out_v_q;
	logic         v_s1;
	logic [3:0]   bits_s1;
	logic         restart_s1;
	logic         adv;

	assign adv       = !out_v_q || dout.ready;
	assign din.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_mode_q <= RATE_9600;
		end else if (cfg_we) begin
			rate_mode_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (din.ready) begin
			v_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			bits_s1    <= din.data_bits;
			restart_s1 <= din.restart;
		end
	end

	v29e_core u_core (
		.st        (st_q),
		.rate_mode (rate_mode_q),
		.data_bits (bits_s1),
		.restart   (restart_s1),
		.st_next   (st_next),
		.res       (res)
	);

	// encoder state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= STATE_INIT;
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
			if (v_s1) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			res_q <= res;
		end
	end

	assign dout.valid      = out_v_q;
	assign dout.point_i    = res_q.point_i;
	assign dout.point_q    = res_q.point_q;
	assign dout.training   = res_q.training;
	assign dout.data_taken = res_q.data_taken;

	// training symbols never consume user bits
	a_train_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.training |-> !dout.data_taken)
		else $error("training symbol marked as data");

	// once training is over the count rests at its end value
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.in_train |-> st_q.train_count == TRAIN_END)
		else $error("train count off end value after training");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.in_train |-> st_q.train_count < TRAIN_END)
		else $error("train count past end while training");

	// an empty output register never holds off the input side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> din.ready)
		else $error("input stalled with empty output");

	// state moves only when a baud passes to the output register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && v_s1) |=> $stable(st_q))
		else $error("encoder state changed without a baud");

endmodule

`default_nettype wire

[hdl/v29e_core.sv]
// ----------------------------------------------------------------------------
// v29e_core
// One baud of training sequencing, scrambling and constellation mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module v29e_core (
	input  v29e_pkg::v29e_state_t  st,
	input  logic [1:0]             rate_mode,
	input  logic [3:0]             data_bits,
	input  logic                   restart,
	output v29e_pkg::v29e_state_t  st_next,
	output v29e_pkg::v29e_result_t res
);
	import v29e_pkg::*;

	v29e_state_t cur;
	logic [22:0] ds;
	logic [3:0]  bits;
	logic [3:0]  o;
	logic [1:0]  skip;
	logic [2:0]  off;
	logic [2:0]  step;
	logic [2:0]  phase_new;
	logic        amp;
	logic [3:0]  pt_idx;
	logic [2:0]  k;
	logic        b;

	always_comb begin
		cur  = restart ? STATE_INIT : st;
		bits = cur.in_train ? 4'hF : data_bits;

		case (rate_mode)
			RATE_7200: begin
				skip = 2'd1;
				off  = 3'd2;
			end
			RATE_4800: begin
				skip = 2'd2;
				off  = 3'd4;
			end
			default: begin
				skip = 2'd0;
				off  = 3'd0;
			end
		endcase

		// data scrambler 1 + x^-18 + x^-23, msb of the used bits first
		ds = cur.data_scr;
		o  = 4'd0;
		for (int j = 0; j < 4; j++) begin
			if (2'(j) >= skip) begin
				o[3 - j] = bits[3 - j] ^ ds[17] ^ ds[22];
				ds       = {ds[21:0], o[3 - j]};
			end
		end

		step      = (rate_mode == RATE_4800) ? STEP4[o[1:0]] : STEP8[o[2:0]];
		phase_new = cur.phase + step;
		amp       = (rate_mode != RATE_7200) && (rate_mode != RATE_4800) && o[3];
		pt_idx    = {amp, phase_new};

		st_next        = cur;
		res.training   = cur.in_train;
		res.data_taken = 1'b0;
		res.point_i    = 4'sd0;
		res.point_q    = 4'sd0;
		b              = cur.train_scr[0];
		k              = off;

		if (!cur.in_train) begin
			res.point_i      = PT_I[pt_idx];
			res.point_q      = PT_Q[pt_idx];
			res.data_taken   = 1'b1;
			st_next.data_scr = ds;
			st_next.phase    = phase_new;
		end else begin
			st_next.train_count = cur.train_count + 10'd1;
			if (cur.train_count < SEG2_START) begin
				// silence
			end else if (cur.train_count < SEG3_START) begin
				k           = off + {2'd0, cur.train_count[0]};
				res.point_i = AB_I[k];
				res.point_q = AB_Q[k];
			end else if (cur.train_count < SEG4_START) begin
				k                 = off + {2'd0, b};
				res.point_i       = CD_I[k];
				res.point_q       = CD_Q[k];
				st_next.train_scr = {cur.train_scr[0] ^ cur.train_scr[1],
					cur.train_scr[6:1]};
			end else begin
				// scrambled ones
				res.point_i      = PT_I[pt_idx];
				res.point_q      = PT_Q[pt_idx];
				st_next.data_scr = ds;
				st_next.phase    = phase_new;
				if (st_next.train_count >= TRAIN_END) begin
					st_next.in_train = 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the V.29 symbol encoder. A table of silence bauds
// with known points is followed by random bauds in phases of different bit
// rates. The phases run the full training sequence, change rate between
// training segments and in data mode, and restart now and then. Each point is
// held to its table entry or an in-bench model. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import v29e_pkg::*;

	localparam logic [1:0] RATE_SPARE = 2'd3;
	localparam int IDLE_PCT = 28;

	// point tables, phase plus 8 for the high amplitude
	localparam coord_t RING_I [16] = '{
		4'sd3, 4'sd1, 4'sd0, -4'sd1, -4'sd3, -4'sd1, 4'sd0, 4'sd1,
		4'sd5, 4'sd3, 4'sd0, -4'sd3, -4'sd5, -4'sd3, 4'sd0, 4'sd3
	};
	localparam coord_t RING_Q [16] = '{
		4'sd0, 4'sd1, 4'sd3, 4'sd1, 4'sd0, -4'sd1, -4'sd3, -4'sd1,
		4'sd0, 4'sd3, 4'sd5, 4'sd3, 4'sd0, -4'sd3, -4'sd5, -4'sd3
	};
	localparam coord_t SEG_AB_I [6] = '{-4'sd3, 4'sd3, -4'sd3, 4'sd1, -4'sd3, 4'sd0};
	localparam coord_t SEG_AB_Q [6] = '{4'sd0, -4'sd3, 4'sd0, -4'sd1, 4'sd0, -4'sd3};
	localparam coord_t SEG_CD_I [6] = '{4'sd3, -4'sd3, 4'sd3, -4'sd1, 4'sd3, 4'sd0};
	localparam coord_t SEG_CD_Q [6] = '{4'sd0, 4'sd3, 4'sd0, 4'sd1, 4'sd0, 4'sd3};
	localparam logic [2:0] GRAY8 [8] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6, 3'd7, 3'd5, 3'd4};
	localparam logic [2:0] GRAY4 [4] = '{3'd0, 3'd2, 3'd6, 3'd4};

	localparam v29e_result_t SILENT = '{
		point_i: 4'sd0, point_q: 4'sd0, training: 1'b1, data_taken: 1'b0
	};

	typedef struct packed {
		logic [3:0]   bits;
		logic         restart;
		logic         typed;
		v29e_result_t want;
	} baud_row_t;

	// silence bauds: data ignored, restarts mixed in
	localparam int N_DIRECTED = 20;
	localparam baud_row_t DIRECTED [N_DIRECTED] = '{
		'{4'hF, 1'b0, 1'b1, SILENT}, '{4'h0, 1'b0, 1'b1, SILENT},
		'{4'hF, 1'b1, 1'b1, SILENT}, '{4'h0, 1'b1, 1'b1, SILENT},
		'{4'h8, 1'b0, 1'b1, SILENT}, '{4'h7, 1'b0, 1'b1, SILENT},
		'{4'h1, 1'b0, 1'b1, SILENT}, '{4'hE, 1'b1, 1'b1, SILENT},
		'{4'h5, 1'b0, 1'b1, SILENT}, '{4'hA, 1'b0, 1'b1, SILENT},
		'{4'h3, 1'b0, 1'b1, SILENT}, '{4'hC, 1'b0, 1'b1, SILENT},
		'{4'h2, 1'b1, 1'b1, SILENT}, '{4'hD, 1'b0, 1'b1, SILENT},
		'{4'h4, 1'b0, 1'b1, SILENT}, '{4'hB, 1'b0, 1'b1, SILENT},
		'{4'h6, 1'b1, 1'b1, SILENT}, '{4'h9, 1'b0, 1'b1, SILENT},
		'{4'hF, 1'b0, 1'b1, SILENT}, '{4'h0, 1'b0, 1'b1, SILENT}
	};

	typedef struct packed {
		logic [1:0] rate;
		int         count;
		logic       restart_first;
		int         restart_pct;
	} rate_phase_t;

	// 7200 -> 4800 falls in the c/d segment, 4800 -> 7200 in the scrambled ones
	localparam int N_PHASES = 8;
	localparam rate_phase_t PHASES [N_PHASES] = '{
		'{RATE_9600, 620, 1'b0, 0},
		'{RATE_7200, 40, 1'b0, 0},
		'{RATE_4800, 40, 1'b0, 0},
		'{RATE_SPARE, 40, 1'b0, 0},
		'{RATE_7200, 200, 1'b1, 0},
		'{RATE_4800, 380, 1'b0, 0},
		'{RATE_7200, 60, 1'b0, 0},
		'{RATE_9600, 60, 1'b0, 3}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	v29e_in_if  din ();
	v29e_out_if dout ();

	v29_symbol_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.din       (din.sink),
		.dout      (dout.source)
	);

	// encoder model state
	logic [22:0] enc_dscr;
	logic [6:0]  enc_tscr;
	logic [2:0]  enc_phase;
	logic [9:0]  enc_count;
	logic        enc_in_train;
	logic [1:0]  enc_rate;

	v29e_result_t points_due [$];
	int           mismatches = 0;
	bit           steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void restart_encoder();
		enc_dscr     = '0;
		enc_tscr     = 7'h2A;
		enc_phase    = '0;
		enc_count    = '0;
		enc_in_train = 1'b1;
	endfunction

	// 1 + x^-18 + x^-23
	function automatic logic scramble_bit(input logic b);
		logic o;
		o = b ^ enc_dscr[17] ^ enc_dscr[22];
		enc_dscr = {enc_dscr[21:0], o};
		return o;
	endfunction

	function automatic logic [3:0] map_bits(input logic [3:0] bits);
		logic       amp;
		logic [2:0] ph;
		logic [2:0] step;
		amp = 1'b0;
		ph = '0;
		if (enc_rate == RATE_4800) begin
			ph[1] = scramble_bit(bits[1]);
			ph[0] = scramble_bit(bits[0]);
			step = GRAY4[ph[1:0]];
		end else begin
			if (enc_rate != RATE_7200)
				amp = scramble_bit(bits[3]);
			ph[2] = scramble_bit(bits[2]);
			ph[1] = scramble_bit(bits[1]);
			ph[0] = scramble_bit(bits[0]);
			step = GRAY8[ph];
		end
		enc_phase = enc_phase + step;
		return {amp, enc_phase};
	endfunction

	function automatic v29e_result_t encode_baud(input logic [3:0] bits, input logic rs);
		v29e_result_t r;
		int           off;
		int           k;
		off = (enc_rate == RATE_7200) ? 2 : ((enc_rate == RATE_4800) ? 4 : 0);
		if (rs)
			restart_encoder();
		r = '{point_i: 4'sd0, point_q: 4'sd0, training: enc_in_train, data_taken: 1'b0};
		if (enc_in_train) begin
			if (enc_count < SEG2_START) begin
				k = 0;
			end else if (enc_count < SEG3_START) begin
				k = off + enc_count[0];
				r.point_i = SEG_AB_I[k];
				r.point_q = SEG_AB_Q[k];
			end else if (enc_count < SEG4_START) begin
				k = off + enc_tscr[0];
				r.point_i = SEG_CD_I[k];
				r.point_q = SEG_CD_Q[k];
				enc_tscr = {enc_tscr[0] ^ enc_tscr[1], enc_tscr[6:1]};
			end else begin
				k = map_bits(4'hF);
				r.point_i = RING_I[k];
				r.point_q = RING_Q[k];
			end
			enc_count = enc_count + 10'd1;
			if (enc_count >= TRAIN_END)
				enc_in_train = 1'b0;
		end else begin
			k = map_bits(bits);
			r.point_i = RING_I[k];
			r.point_q = RING_Q[k];
			r.data_taken = 1'b1;
		end
		return r;
	endfunction

	task automatic send_baud(input logic [3:0] bits, input logic rs, input logic typed,
			input v29e_result_t want);
		v29e_result_t predicted;
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				din.valid <= 1'b0;
				@(posedge clk);
			end
		end
		din.valid     <= 1'b1;
		din.data_bits <= bits;
		din.restart   <= rs;
		do @(posedge clk); while (din.ready !== 1'b1);
		predicted = encode_baud(bits, rs);
		points_due.push_back(typed ? want : predicted);
	endtask

	task automatic drain_points();
		while (points_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_rate(input logic [1:0] rate);
		cfg_we    <= 1'b1;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_we   <= 1'b0;
		enc_rate = rate;
	endtask

	task automatic check_field(input string name, input integer want, input integer got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// receive side: random stalls, compare each transfer with the oldest entry
	initial begin
		v29e_result_t want;
		dout.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (dout.valid === 1'b1 && dout.ready === 1'b1) begin
				if (points_due.size() == 0) begin
					$display("%0t: no point expected, actual i=%0d q=%0d trn=%0b taken=%0b",
						$time, dout.point_i, dout.point_q, dout.training, dout.data_taken);
					mismatches++;
				end else begin
					want = points_due.pop_front();
					check_field("point_i", want.point_i, dout.point_i);
					check_field("point_q", want.point_q, dout.point_q);
					check_field("training", want.training, dout.training);
					check_field("data_taken", want.data_taken, dout.data_taken);
				end
			end
			dout.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		logic [3:0] bits;
		logic       rs;
		din.valid     <= 1'b0;
		din.data_bits <= 4'h0;
		din.restart   <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= RATE_9600;
		arst_n        <= 1'b0;
		restart_encoder();
		enc_rate = RATE_9600;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_rate(RATE_9600);

		for (int n = 0; n < N_DIRECTED; n++)
			send_baud(DIRECTED[n].bits, DIRECTED[n].restart, DIRECTED[n].typed,
				DIRECTED[n].want);

		for (int p = 0; p < N_PHASES; p++) begin
			din.valid <= 1'b0;
			drain_points();
			set_rate(PHASES[p].rate);
			for (int n = 0; n < PHASES[p].count; n++) begin
				steady = (p == 0) && (n >= 200) && (n < 400);
				bits = 4'($urandom_range(15));
				if (n == 0 && PHASES[p].restart_first)
					rs = 1'b1;
				else
					rs = ($urandom_range(99) < PHASES[p].restart_pct);
				send_baud(bits, rs, 1'b0, SILENT);
			end
		end

		din.valid <= 1'b0;
		while (points_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
